// ===== hw/rtl/ffwp_pkg.sv =====
// Shared types, constants and helpers for the first-fit window placement block.
package ffwp_pkg;

  localparam int unsigned MAX_WINDOWS_DEF = 64;
  localparam int unsigned POS_W = 19;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_PLACE = 2'd2;

  localparam logic [1:0] TAB_TOP    = 2'd0;
  localparam logic [1:0] TAB_BOTTOM = 2'd1;
  localparam logic [1:0] TAB_LEFT   = 2'd2;
  localparam logic [1:0] TAB_RIGHT  = 2'd3;

  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BORDER_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TAB_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_TAB_WIDTH     = 3'd4;
  localparam logic [2:0] REG_MODE_BITS     = 3'd5;
  localparam logic [2:0] REG_TOOLBAR_POS   = 3'd6;
  localparam logic [2:0] REG_TOOLBAR_SIZE  = 3'd7;

  localparam logic [15:0] CASCADE_START = 16'd32;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [13:0]        win_width;
    logic [13:0]        win_height;
    logic [7:0]         title_height;
    logic               is_shaded;
    logic               has_tab;
  } in_t;

  typedef struct packed {
    logic signed [15:0] place_x;
    logic signed [15:0] place_y;
    logic               smart_found;
    logic               table_full;
  } out_t;

  typedef struct packed {
    logic [13:0] screen_width;
    logic [13:0] screen_height;
    logic [7:0]  border_width;
    logic [7:0]  tab_height;
    logic [11:0] tab_width;
    logic [6:0]  mode_bits;
    logic [31:0] toolbar_position;
    logic [31:0] toolbar_size;
  } cfg_t;

  typedef struct packed {
    logic        tab;
    logic        shaded;
    logic [7:0]  title;
    logic [13:0] h;
    logic [13:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic add_commit;
    logic prep;
    logic o_init;
    logic o_step;
    logic i_init;
    logic i_next;
    logic k_clr;
    logic expand;
    logic test;
    logic take_found;
    logic cascade;
    logic center;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic o_ok;
    logic i_ok;
    logic k_last;
    logic hit;
    logic scan_en;
    logic slot_free;
  } ctrl_sts_t;

  // signed halving, truncated toward zero
  function automatic pos_t half_tz(pos_t v);
    pos_t t;
    t = v + {{(POS_W-1){1'b0}}, v[POS_W-1]};
    return t >>> 1;
  endfunction

endpackage

// ===== hw/rtl/ffwp_ctrl.sv =====
// Sequencer for add, clear and the placement scan.
module ffwp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_cmd_i,
  output logic                 in_stall_o,
  input  ffwp_pkg::ctrl_sts_t  sts_i,
  output ffwp_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_ADD    = 14'b00000000000010,
    S_PREP   = 14'b00000000000100,
    S_OINIT  = 14'b00000000001000,
    S_OCHK   = 14'b00000000010000,
    S_IINIT  = 14'b00000000100000,
    S_ICHK   = 14'b00000001000000,
    S_RD     = 14'b00000010000000,
    S_EXP    = 14'b00000100000000,
    S_TST    = 14'b00001000000000,
    S_DECIDE = 14'b00010000000000,
    S_CASC   = 14'b00100000000000,
    S_FIN1   = 14'b01000000000000,
    S_FIN2   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          if (in_cmd_i == ffwp_pkg::CMD_ADD) begin
            state_d = S_ADD;
          end else if (in_cmd_i == ffwp_pkg::CMD_PLACE) begin
            state_d = S_PREP;
          end
        end
      end
      S_ADD: begin
        if (sts_i.slot_free) begin
          cmd_o.add_commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = sts_i.scan_en ? S_OINIT : S_CASC;
      end
      S_OINIT: begin
        cmd_o.o_init = 1'b1;
        state_d = S_OCHK;
      end
      S_OCHK: begin
        state_d = sts_i.o_ok ? S_IINIT : S_CASC;
      end
      S_IINIT: begin
        cmd_o.i_init = 1'b1;
        state_d = S_ICHK;
      end
      S_ICHK: begin
        if (sts_i.i_ok) begin
          cmd_o.k_clr = 1'b1;
          state_d = S_RD;
        end else begin
          cmd_o.o_step = 1'b1;
          state_d = S_OCHK;
        end
      end
      S_RD: begin
        state_d = S_EXP;
      end
      S_EXP: begin
        cmd_o.expand = 1'b1;
        state_d = S_TST;
      end
      S_TST: begin
        cmd_o.test = 1'b1;
        state_d = sts_i.k_last ? S_DECIDE : S_RD;
      end
      S_DECIDE: begin
        if (sts_i.hit) begin
          cmd_o.i_next = 1'b1;
          state_d = S_ICHK;
        end else begin
          cmd_o.take_found = 1'b1;
          state_d = S_FIN1;
        end
      end
      S_CASC: begin
        cmd_o.cascade = 1'b1;
        state_d = S_FIN1;
      end
      S_FIN1: begin
        cmd_o.center = 1'b1;
        state_d = S_FIN2;
      end
      S_FIN2: begin
        if (sts_i.slot_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/ffwp_dp.sv =====
// Datapath: window table, scan position counters, overlap test and result register.
module ffwp_dp #(
  parameter int unsigned MAX_WINDOWS = ffwp_pkg::MAX_WINDOWS_DEF,
  parameter int unsigned CNT_W = $clog2(MAX_WINDOWS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffwp_pkg::cfg_t       cfg_i,
  input  ffwp_pkg::in_t        in_data_i,
  input  ffwp_pkg::ctrl_cmd_t  cmd_i,
  output ffwp_pkg::ctrl_sts_t  sts_o,
  output logic [CNT_W-1:0]     count_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ffwp_pkg::out_t       out_data_o
);

  localparam int unsigned AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

  ffwp_pkg::entry_t mem_q [MAX_WINDOWS];
  ffwp_pkg::entry_t rd_q;
  ffwp_pkg::in_t    in_q;
  logic [CNT_W-1:0] count_q, k_q;
  logic [15:0]      cas_x_q, cas_y_q;
  ffwp_pkg::pos_t   ww_q, wh_q, o_q, i_q, next_q, px_q, py_q;
  ffwp_pkg::pos_t   oa_q, ol_q, ia_q, il_q;
  logic             hit_q, found_q, out_valid_q;
  ffwp_pkg::out_t   out_q;

  logic [1:0]     tab;
  logic           col, orev, irev, full, wide_tab, cas_rst, ovl, better;
  logic [8:0]     b2;
  logic [11:0]    side;
  logic [15:0]    cas_ux, cas_uy;
  ffwp_pkg::pos_t sw, sh, th, sd, b2p, olen, ow, ilen, iw;
  ffwp_pkg::pos_t ww_n, wh_n, cx, cy, cw, ch, e_val, cen_x, cen_y;

  assign tab  = cfg_i.mode_bits[5:4];
  assign col  = cfg_i.mode_bits[0];
  assign b2   = {cfg_i.border_width, 1'b0};
  assign side = cfg_i.mode_bits[6] ? {4'd0, cfg_i.tab_height} : cfg_i.tab_width;
  assign sw   = {5'd0, cfg_i.screen_width};
  assign sh   = {5'd0, cfg_i.screen_height};
  assign th   = {11'd0, cfg_i.tab_height};
  assign sd   = {7'd0, side};
  assign b2p  = {10'd0, b2};

  assign olen = col ? sw : sh;
  assign ow   = col ? ww_q : wh_q;
  assign orev = col ? cfg_i.mode_bits[2] : cfg_i.mode_bits[3];
  assign ilen = col ? sh : sw;
  assign iw   = col ? wh_q : ww_q;
  assign irev = col ? cfg_i.mode_bits[3] : cfg_i.mode_bits[2];

  assign full = (count_q >= CNT_W'(MAX_WINDOWS));

  assign wide_tab = in_q.has_tab &&
                    ((!in_q.is_shaded && tab == ffwp_pkg::TAB_LEFT) ||
                     tab == ffwp_pkg::TAB_RIGHT);
  assign ww_n = {5'd0, in_q.win_width} + b2p + (wide_tab ? sd : '0);
  assign wh_n = {5'd0, in_q.win_height} + b2p +
                ((in_q.has_tab && !wide_tab) ? th : '0);

  // expanded rectangle of the current entry, or the toolbar after the last one
  always_comb begin
    if (k_q == count_q) begin
      cx = {{3{cfg_i.toolbar_position[15]}}, cfg_i.toolbar_position[15:0]};
      cy = {{3{cfg_i.toolbar_position[31]}}, cfg_i.toolbar_position[31:16]};
      cw = {3'd0, cfg_i.toolbar_size[15:0]};
      ch = {3'd0, cfg_i.toolbar_size[31:16]};
    end else begin
      cx = {{3{rd_q.x[15]}}, rd_q.x};
      cy = {{3{rd_q.y[15]}}, rd_q.y};
      cw = {5'd0, rd_q.w} + b2p;
      ch = (rd_q.shaded ? {11'd0, rd_q.title} : {5'd0, rd_q.h}) + b2p;
      if (rd_q.tab) begin
        if (!rd_q.shaded) begin
          unique case (tab)
            ffwp_pkg::TAB_TOP: begin
              cy = cy - th;
              ch = ch + th;
            end
            ffwp_pkg::TAB_BOTTOM: ch = ch + th;
            ffwp_pkg::TAB_LEFT: begin
              cx = cx - sd;
              cw = cw + sd;
            end
            default: cw = cw + sd;
          endcase
        end else begin
          if (tab == ffwp_pkg::TAB_TOP) cy = cy - th;
          ch = ch + th;
        end
      end
    end
  end

  assign ovl = (oa_q < o_q + ow) && (oa_q + ol_q > o_q) &&
               (ia_q < i_q + iw) && (ia_q + il_q > i_q);
  assign e_val  = irev ? (ia_q - iw) : (ia_q + il_q);
  assign better = !hit_q || (irev ? (e_val < next_q) : (e_val > next_q));

  assign cas_rst = (cas_x_q > {3'd0, cfg_i.screen_width[13:1]}) ||
                   (cas_y_q > {3'd0, cfg_i.screen_height[13:1]});
  assign cas_ux  = cas_rst ? ffwp_pkg::CASCADE_START : cas_x_q;
  assign cas_uy  = cas_rst ? ffwp_pkg::CASCADE_START : cas_y_q;

  assign cen_x = ffwp_pkg::half_tz(sw - ww_q);
  assign cen_y = ffwp_pkg::half_tz(sh - wh_q);

  assign sts_o.o_ok      = orev ? (o_q > 0) : (o_q + ow < olen);
  assign sts_o.i_ok      = irev ? (i_q > 0) : (i_q + iw < ilen);
  assign sts_o.k_last    = (k_q == count_q);
  assign sts_o.hit       = hit_q;
  assign sts_o.scan_en   = !cfg_i.mode_bits[1];
  assign sts_o.slot_free = !out_valid_q || !out_stall_i;

  assign count_o     = count_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_commit && !full) begin
      mem_q[count_q[AW-1:0]] <= {in_q.has_tab, in_q.is_shaded, in_q.title_height,
                                 in_q.win_height, in_q.win_width,
                                 in_q.pos_y, in_q.pos_x};
    end
    rd_q <= mem_q[k_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) in_q <= in_data_i;
    if (cmd_i.prep) begin
      ww_q <= ww_n;
      wh_q <= wh_n;
    end
    if (cmd_i.o_init) o_q <= orev ? (olen - ow) : '0;
    if (cmd_i.o_step) o_q <= orev ? (o_q - ffwp_pkg::pos_t'(1)) : (o_q + ffwp_pkg::pos_t'(1));
    if (cmd_i.i_init) i_q <= irev ? (ilen - iw) : '0;
    if (cmd_i.i_next) i_q <= next_q;
    if (cmd_i.expand) begin
      oa_q <= col ? cx : cy;
      ol_q <= col ? cw : ch;
      ia_q <= col ? cy : cx;
      il_q <= col ? ch : cw;
    end
    if (cmd_i.test && ovl && better) next_q <= e_val;
    if (cmd_i.take_found) begin
      px_q    <= col ? o_q : i_q;
      py_q    <= col ? i_q : o_q;
      found_q <= 1'b1;
    end
    if (cmd_i.cascade) begin
      px_q    <= {3'd0, cas_ux};
      py_q    <= {3'd0, cas_uy};
      found_q <= 1'b0;
    end
    if (cmd_i.center) begin
      if (px_q + ww_q > sw) px_q <= cen_x;
      if (py_q + wh_q > sh) py_q <= cen_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      k_q         <= '0;
      hit_q       <= 1'b0;
      cas_x_q     <= ffwp_pkg::CASCADE_START;
      cas_y_q     <= ffwp_pkg::CASCADE_START;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cmd_i.latch && in_data_i.cmd == ffwp_pkg::CMD_CLEAR) count_q <= '0;
      if (cmd_i.add_commit && !full) count_q <= count_q + 1'b1;
      if (cmd_i.k_clr) begin
        k_q   <= '0;
        hit_q <= 1'b0;
      end
      if (cmd_i.test) begin
        k_q <= k_q + 1'b1;
        if (ovl) hit_q <= 1'b1;
      end
      if (cmd_i.cascade) begin
        cas_x_q <= cas_ux + {8'd0, in_q.title_height};
        cas_y_q <= cas_uy + {8'd0, in_q.title_height};
      end
      if (cmd_i.add_commit) begin
        out_valid_q <= 1'b1;
        out_q       <= '{place_x: '0, place_y: '0, smart_found: 1'b0, table_full: full};
      end else if (cmd_i.finish) begin
        out_valid_q       <= 1'b1;
        out_q.place_x     <= px_q[15:0] + ((in_q.has_tab && tab == ffwp_pkg::TAB_LEFT) ?
                                           sd[15:0] : 16'd0);
        out_q.place_y     <= py_q[15:0] + ((in_q.has_tab && tab == ffwp_pkg::TAB_TOP) ?
                                           th[15:0] : 16'd0);
        out_q.smart_found <= found_q;
        out_q.table_full  <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/first_fit_window_placement_top.sv =====
// From accept to result: an add waits in S_ADD for a free output slot; a place runs S_PREP,
// then the scan or the cascade fallback (S_CASC), then S_FIN1 (recentres an off-screen result)
// and S_FIN2, which waits for a free slot. Each candidate reads every entry and the toolbar.
// One item at a time; clear and unused commands finish in their accept cycle. A scan
// visits up to screen_width*screen_height positions, bounded by the screen size registers.
// Reset: table empty, cascade at 32,32, registers at their defaults; table not cleared.
module first_fit_window_placement_top #(
  parameter int unsigned MAX_WINDOWS = ffwp_pkg::MAX_WINDOWS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ffwp_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ffwp_pkg::out_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOWS + 1);

  ffwp_pkg::cfg_t      cfg_q;
  ffwp_pkg::ctrl_cmd_t cmd;
  ffwp_pkg::ctrl_sts_t sts;
  logic [CNT_W-1:0]    count;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width     <= 14'd1024;
      cfg_q.screen_height    <= 14'd768;
      cfg_q.border_width     <= 8'd1;
      cfg_q.tab_height       <= 8'd16;
      cfg_q.tab_width        <= 12'd64;
      cfg_q.mode_bits        <= 7'd0;
      cfg_q.toolbar_position <= 32'd0;
      cfg_q.toolbar_size     <= 32'd0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        ffwp_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width     <= pwdata[13:0];
        ffwp_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height    <= pwdata[13:0];
        ffwp_pkg::REG_BORDER_WIDTH:  cfg_q.border_width     <= pwdata[7:0];
        ffwp_pkg::REG_TAB_HEIGHT:    cfg_q.tab_height       <= pwdata[7:0];
        ffwp_pkg::REG_TAB_WIDTH:     cfg_q.tab_width        <= pwdata[11:0];
        ffwp_pkg::REG_MODE_BITS:     cfg_q.mode_bits        <= pwdata[6:0];
        ffwp_pkg::REG_TOOLBAR_POS:   cfg_q.toolbar_position <= pwdata;
        default:                     cfg_q.toolbar_size     <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ffwp_pkg::REG_SCREEN_WIDTH:  prdata = {18'd0, cfg_q.screen_width};
      ffwp_pkg::REG_SCREEN_HEIGHT: prdata = {18'd0, cfg_q.screen_height};
      ffwp_pkg::REG_BORDER_WIDTH:  prdata = {24'd0, cfg_q.border_width};
      ffwp_pkg::REG_TAB_HEIGHT:    prdata = {24'd0, cfg_q.tab_height};
      ffwp_pkg::REG_TAB_WIDTH:     prdata = {20'd0, cfg_q.tab_width};
      ffwp_pkg::REG_MODE_BITS:     prdata = {25'd0, cfg_q.mode_bits};
      ffwp_pkg::REG_TOOLBAR_POS:   prdata = cfg_q.toolbar_position;
      default:                     prdata = cfg_q.toolbar_size;
    endcase
  end

  ffwp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffwp_dp #(
    .MAX_WINDOWS (MAX_WINDOWS),
    .CNT_W       (CNT_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .count_o     (count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(MAX_WINDOWS))
    else $error("table count beyond capacity");

  a_add_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.cmd == ffwp_pkg::CMD_ADD) |=> in_stall_o)
    else $error("add item not held busy");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.smart_found && out_data_o.table_full))
    else $error("found and full flags both set");
`endif

endmodule
